@@ design/hso_pkg.sv @@
// Shared constants, types and field helpers for the hyperslab offset walker.
package hso_pkg;

  localparam int MAX_DIMS  = 4;
  localparam int DIM_BITS  = 16;
  localparam int DIM_IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int RANK_W    = 3;
  localparam int ESL_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int DESC_W    = 64;
  localparam int OFFSET_W  = 64;
  localparam int ORD_W     = 64;
  localparam int ERR_W     = 3;

  localparam int SIZE_LSB   = 48;
  localparam int START_LSB  = 32;
  localparam int STRIDE_LSB = 16;
  localparam int STOP_LSB   = 0;

  localparam logic [DESC_W-1:0] DESC_RESET = 64'h0001_0000_0001_0000;

  localparam logic [CFG_IDX_W-1:0] REG_RANK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM0 = 3'd2;

  localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_START     = 3'd1;
  localparam logic [ERR_W-1:0] ERR_STRIDE    = 3'd2;
  localparam logic [ERR_W-1:0] ERR_BEYOND    = 3'd3;
  localparam logic [ERR_W-1:0] ERR_EXHAUSTED = 3'd4;

  typedef logic [DIM_BITS-1:0] dim_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_HORN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic eval;
    logic horn_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic eval_err;
    logic horn_done;
    logic out_free;
  } dp_stat_t;

  function automatic dim_t desc_size(input logic [DESC_W-1:0] desc);
    return desc[SIZE_LSB +: DIM_BITS];
  endfunction

  function automatic dim_t desc_start(input logic [DESC_W-1:0] desc);
    return desc[START_LSB +: DIM_BITS];
  endfunction

  function automatic dim_t desc_stride(input logic [DESC_W-1:0] desc);
    return desc[STRIDE_LSB +: DIM_BITS];
  endfunction

  function automatic dim_t desc_stop(input logic [DESC_W-1:0] desc);
    return desc[STOP_LSB +: DIM_BITS];
  endfunction

endpackage

@@ design/hso_if.sv @@
// Channel interfaces: request, result and register write.
interface hso_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface hso_out_if;
  logic                          valid;
  logic                          ready;
  logic [hso_pkg::OFFSET_W-1:0]  byte_offset;
  logic [hso_pkg::ORD_W-1:0]     element_ordinal;
  logic                          last_element;
  logic [hso_pkg::ERR_W-1:0]     error_code;

  modport source (output valid, output byte_offset, output element_ordinal,
                  output last_element, output error_code, input ready);
  modport sink   (input valid, input byte_offset, input element_ordinal,
                  input last_element, input error_code, output ready);
endinterface

interface hso_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hso_pkg::CFG_IDX_W-1:0] index;
  logic [hso_pkg::DESC_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/hso_ctrl.sv @@
// Controller state machine: sequences check/advance, offset build and result load.
module hso_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hso_pkg::dp_stat_t  stat,
  output hso_pkg::ctrl_cmd_t cmd
);

  hso_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hso_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      hso_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = hso_pkg::ST_EVAL;
        end
      end
      hso_pkg::ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.eval_err ? hso_pkg::ST_EMIT : hso_pkg::ST_HORN;
      end
      hso_pkg::ST_HORN: begin
        if (stat.horn_done) begin
          state_nxt = hso_pkg::ST_EMIT;
        end else begin
          cmd.horn_step = 1'b1;
        end
      end
      hso_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = hso_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hso_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == hso_pkg::ST_EVAL)
    else $error("accept did not lead to evaluation");

  a_emit_waits_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result loaded while output slot busy");

  a_eval_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hso_pkg::ST_EVAL |=> state_r == hso_pkg::ST_HORN || state_r == hso_pkg::ST_EMIT)
    else $error("evaluation lasted more than one cycle");
`endif

endmodule

@@ design/hso_datapath.sv @@
// Datapath: registers, position counters, multiply-add offset unit and result register.
module hso_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hso_pkg::ctrl_cmd_t            cmd,
  output hso_pkg::dp_stat_t             stat,
  input  logic                          in_restart,
  input  logic                          cfg_valid,
  input  logic [hso_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hso_pkg::DESC_W-1:0]    cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hso_pkg::OFFSET_W-1:0]  out_byte_offset,
  output logic [hso_pkg::ORD_W-1:0]     out_element_ordinal,
  output logic                          out_last_element,
  output logic [hso_pkg::ERR_W-1:0]     out_error_code
);

  logic [hso_pkg::RANK_W-1:0]   rank_r;
  logic [hso_pkg::ESL_W-1:0]    esl_r;
  logic [hso_pkg::DESC_W-1:0]   desc_r [hso_pkg::MAX_DIMS];

  hso_pkg::dim_t                pos_r [hso_pkg::MAX_DIMS];
  hso_pkg::dim_t                pos_nxt [hso_pkg::MAX_DIMS];
  logic [hso_pkg::ORD_W-1:0]    ord_r, ord_nxt;
  logic                         walk_r, walk_nxt;
  logic                         restart_r;
  logic [hso_pkg::ERR_W-1:0]    err_r;
  logic [hso_pkg::OFFSET_W-1:0] acc_r, acc_nxt;
  logic [hso_pkg::RANK_W-1:0]   idx_r;

  logic                         out_valid_r;
  logic [hso_pkg::OFFSET_W-1:0] out_offset_r;
  logic [hso_pkg::ORD_W-1:0]    out_ord_r;
  logic                         out_last_r;
  logic [hso_pkg::ERR_W-1:0]    out_err_r;

  logic [hso_pkg::RANK_W-1:0]   rank_used;
  logic [hso_pkg::MAX_DIMS-1:0] dim_act;
  logic [hso_pkg::ERR_W-1:0]    chk_code;
  hso_pkg::dim_t                adv_pos [hso_pkg::MAX_DIMS];
  logic                         adv_carry;
  logic [hso_pkg::ERR_W-1:0]    eval_code;
  logic                         last_c;
  logic [hso_pkg::OFFSET_W+hso_pkg::DIM_BITS-1:0] prod;
  logic                         ok;

  // rank clamp
  always_comb begin
    if (rank_r == '0) begin
      rank_used = hso_pkg::RANK_W'(1);
    end else if (rank_r > hso_pkg::RANK_W'(hso_pkg::MAX_DIMS)) begin
      rank_used = hso_pkg::RANK_W'(hso_pkg::MAX_DIMS);
    end else begin
      rank_used = rank_r;
    end
    for (int d = 0; d < hso_pkg::MAX_DIMS; d++) begin
      dim_act[d] = hso_pkg::RANK_W'(d) < rank_used;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= hso_pkg::RANK_W'(1);
      esl_r  <= '0;
      for (int d = 0; d < hso_pkg::MAX_DIMS; d++) begin
        desc_r[d] <= hso_pkg::DESC_RESET;
      end
    end else if (cfg_valid) begin
      if (cfg_index == hso_pkg::REG_RANK) begin
        rank_r <= cfg_data[hso_pkg::RANK_W-1:0];
      end
      if (cfg_index == hso_pkg::REG_ESL) begin
        esl_r <= cfg_data[hso_pkg::ESL_W-1:0];
      end
      for (int d = 0; d < hso_pkg::MAX_DIMS; d++) begin
        if (cfg_index == hso_pkg::REG_DIM0 + hso_pkg::CFG_IDX_W'(d)) begin
          desc_r[d] <= cfg_data;
        end
      end
    end
  end

  // restart checks, outermost failing dimension wins
  always_comb begin
    chk_code = hso_pkg::ERR_OK;
    for (int d = 0; d < hso_pkg::MAX_DIMS; d++) begin
      if (dim_act[d] && chk_code == hso_pkg::ERR_OK) begin
        if (hso_pkg::desc_start(desc_r[d]) > hso_pkg::desc_stop(desc_r[d])) begin
          chk_code = hso_pkg::ERR_START;
        end else if (hso_pkg::desc_stride(desc_r[d]) == '0) begin
          chk_code = hso_pkg::ERR_STRIDE;
        end else if (hso_pkg::desc_stop(desc_r[d]) >= hso_pkg::desc_size(desc_r[d])) begin
          chk_code = hso_pkg::ERR_BEYOND;
        end
      end
    end
  end

  // advance: innermost runs fastest, carry outward
  always_comb begin
    logic                      carry;
    logic [hso_pkg::DIM_BITS:0] sum;
    carry = 1'b1;
    for (int d = hso_pkg::MAX_DIMS - 1; d >= 0; d--) begin
      adv_pos[d] = pos_r[d];
      sum = {1'b0, pos_r[d]} + {1'b0, hso_pkg::desc_stride(desc_r[d])};
      if (dim_act[d] && carry) begin
        if (sum <= {1'b0, hso_pkg::desc_stop(desc_r[d])}) begin
          adv_pos[d] = sum[hso_pkg::DIM_BITS-1:0];
          carry      = 1'b0;
        end else begin
          adv_pos[d] = hso_pkg::desc_start(desc_r[d]);
        end
      end
    end
    adv_carry = carry;
  end

  always_comb begin
    pos_nxt = pos_r;
    ord_nxt = ord_r;
    if (restart_r) begin
      eval_code = chk_code;
      if (chk_code == hso_pkg::ERR_OK) begin
        for (int d = 0; d < hso_pkg::MAX_DIMS; d++) begin
          if (dim_act[d]) begin
            pos_nxt[d] = hso_pkg::desc_start(desc_r[d]);
          end
        end
        ord_nxt = '0;
      end
    end else if (!walk_r) begin
      eval_code = hso_pkg::ERR_EXHAUSTED;
    end else begin
      pos_nxt   = adv_pos;
      eval_code = adv_carry ? hso_pkg::ERR_EXHAUSTED : hso_pkg::ERR_OK;
      if (!adv_carry) begin
        ord_nxt = ord_r + hso_pkg::ORD_W'(1);
      end
    end
  end

  // offset unit: acc = acc * size[idx] + pos[idx]
  assign prod    = {{hso_pkg::DIM_BITS{1'b0}}, acc_r}
                 * {{hso_pkg::OFFSET_W{1'b0}},
                    hso_pkg::desc_size(desc_r[idx_r[hso_pkg::DIM_IDX_W-1:0]])};
  assign acc_nxt = prod[hso_pkg::OFFSET_W-1:0]
                 + hso_pkg::OFFSET_W'(pos_r[idx_r[hso_pkg::DIM_IDX_W-1:0]]);

  always_comb begin
    last_c = 1'b1;
    for (int d = 0; d < hso_pkg::MAX_DIMS; d++) begin
      if (dim_act[d] && ({1'b0, pos_r[d]} + {1'b0, hso_pkg::desc_stride(desc_r[d])})
                        <= {1'b0, hso_pkg::desc_stop(desc_r[d])}) begin
        last_c = 1'b0;
      end
    end
  end

  assign ok       = err_r == hso_pkg::ERR_OK;
  assign walk_nxt = ok && !last_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < hso_pkg::MAX_DIMS; d++) begin
        pos_r[d] <= '0;
      end
      ord_r  <= '0;
      walk_r <= 1'b0;
    end else begin
      if (cmd.eval) begin
        pos_r <= pos_nxt;
        ord_r <= ord_nxt;
      end
      if (cmd.emit) begin
        walk_r <= walk_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      restart_r <= in_restart;
    end
    if (cmd.eval) begin
      err_r <= eval_code;
      acc_r <= hso_pkg::OFFSET_W'(pos_nxt[0]);
      idx_r <= hso_pkg::RANK_W'(1);
    end else if (cmd.horn_step) begin
      acc_r <= acc_nxt;
      idx_r <= idx_r + hso_pkg::RANK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_offset_r <= ok ? (acc_r << esl_r) : '0;
      out_ord_r    <= ok ? ord_r : '0;
      out_last_r   <= ok && last_c;
      out_err_r    <= err_r;
    end
  end

  assign stat.eval_err  = eval_code != hso_pkg::ERR_OK;
  assign stat.horn_done = idx_r == rank_used;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_byte_offset     = out_offset_r;
  assign out_element_ordinal = out_ord_r;
  assign out_last_element    = out_last_r;
  assign out_error_code      = out_err_r;

`ifndef SYNTHESIS
  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r != hso_pkg::ERR_OK |->
      out_offset_r == '0 && out_ord_r == '0 && !out_last_r)
    else $error("error result carries non-zero fields");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && ok && last_c |=> !walk_r)
    else $error("walk still active after final element");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.horn_step |-> idx_r < rank_used)
    else $error("offset step beyond rank");

  a_err_clears_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && !ok |=> !walk_r)
    else $error("walk active after error result");
`endif

endmodule

@@ design/hyperslab_offset_walker.sv @@
// Top level of the hyperslab offset walker: channels, controller and datapath.
//
//   channel   modport   payload                                           transfer
//   in_if     sink      restart                                           valid & ready
//   out_if    source    byte_offset, element_ordinal, last_element,       valid & ready
//                       error_code
//   cfg_if    sink      index, data                                       valid & ready
//
// An item runs from its transfer through the check or advance step, then the build of
// the row-major index on a shared 64x16 multiply-add (skipped when checks fail or the
// walk is exhausted), then the result load; no new request is taken before that load.
// Reset (rst_n low, synchronous) gives rank 1, element size 1 and no walk. A waiting
// result sits in the output register; the next request is still taken and held only
// at the result load until out_if.ready frees it.
module hyperslab_offset_walker (
  input  logic      clk,
  input  logic      rst_n,
  hso_in_if.sink    in_if,
  hso_out_if.source out_if,
  hso_cfg_if.sink   cfg_if
);

  hso_pkg::ctrl_cmd_t cmd;
  hso_pkg::dp_stat_t  stat;

  assign cfg_if.ready = 1'b1;

  hso_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hso_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_restart          (in_if.restart),
    .cfg_valid           (cfg_if.valid),
    .cfg_index           (cfg_if.index),
    .cfg_data            (cfg_if.data),
    .out_valid           (out_if.valid),
    .out_ready           (out_if.ready),
    .out_byte_offset     (out_if.byte_offset),
    .out_element_ordinal (out_if.element_ordinal),
    .out_last_element    (out_if.last_element),
    .out_error_code      (out_if.error_code)
  );

endmodule
